// ===== rtl/cws_pkg.sv =====
// Shared types and constants for the capacitance window statistics block.
package cws_pkg;
    localparam int unsigned DefWindowDepth = 1024;
    localparam int unsigned DefCapdacMax   = 31;
    localparam int unsigned ValW           = 26;
    localparam int unsigned VarW           = 64;
    localparam int unsigned CapW           = 5;
    localparam int unsigned TotalW         = 11;
    localparam logic [ValW-1:0] ValMax     = '1;
    localparam logic [0:0] RegThreshold    = 1'b0;
    localparam logic [0:0] RegSatLimit     = 1'b1;
    localparam logic [0:0] OpSample        = 1'b0;
    localparam logic [0:0] OpWindowEnd     = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MEAN_GO, ST_MEAN_WAIT, ST_RD, ST_SQ, ST_ACC,
        ST_VAR_GO, ST_VAR_WAIT, ST_SQRT_GO, ST_SQRT_WAIT, ST_FINISH
    } t_state;

    typedef struct packed {
        logic start;
        logic sqrt_mode;
    } t_unit_req;
endpackage

// ===== rtl/cws_divsqrt.sv =====
// Shared bit-serial unit: restoring divide or integer square root.
module cws_divsqrt #(
    parameter int unsigned CW = 11
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  cws_pkg::t_unit_req       i_req,
    input  logic [cws_pkg::VarW-1:0] i_a,
    input  logic [CW-1:0]            i_b,
    output logic                     o_done,
    output logic [cws_pkg::VarW-1:0] o_res
);
    import cws_pkg::*;

    localparam int unsigned RW = 35;

    logic              r_busy;
    logic              r_sqrt;
    logic [5:0]        r_cnt;
    logic [VarW-1:0]   r_q;
    logic [RW-1:0]     r_rem;
    logic [31:0]       r_root;
    logic [CW-1:0]     r_div;
    logic              r_done;

    logic [CW:0]       d_sh;
    logic              d_ge;
    logic [RW-1:0]     s_sh;
    logic [RW-1:0]     s_trial;
    logic              s_ge;
    logic              last;

    always_comb begin
        d_sh    = {r_rem[CW-1:0], r_q[VarW-1]};
        d_ge    = d_sh >= {1'b0, r_div};
        s_sh    = {r_rem[RW-3:0], r_q[VarW-1:VarW-2]};
        s_trial = {1'b0, r_root, 2'b01};
        s_ge    = s_sh >= s_trial;
        last    = r_sqrt ? (r_cnt == 6'd31) : (r_cnt == 6'd63);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_sqrt <= i_req.sqrt_mode;
            r_q    <= i_a;
            r_div  <= i_b;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            if (r_sqrt) begin
                r_rem  <= s_ge ? s_sh - s_trial : s_sh;
                r_root <= {r_root[30:0], s_ge};
                r_q    <= {r_q[VarW-3:0], 2'b00};
            end else begin
                r_rem  <= {{(RW-CW-1){1'b0}}, d_ge ? d_sh - {1'b0, r_div} : d_sh};
                r_q    <= {r_q[VarW-2:0], d_ge};
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_sqrt ? {32'b0, r_root} : r_q;
endmodule

// ===== rtl/capacitance_window_statistics_top.sv =====
// Top level: sample intake, window store, sequencer and output register.
// Sample beat: result registered at acceptance; ready again once it is taken.
// Window-end beat: mean divide, store walk (read, square and accumulate states per
// sample), variance divide and square root, all on one shared bit-serial divide/sqrt
// unit; windows with a zero sum go straight to the finish state.
// Synchronous active-low reset clears control, window state and config registers; store and datapath are not cleared.
module capacitance_window_statistics_top #(
    parameter int unsigned WINDOW_DEPTH = cws_pkg::DefWindowDepth,
    parameter int unsigned CAPDAC_MAX   = cws_pkg::DefCapdacMax
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // raw_high[15:0], raw_low[31:16]
    input  logic         s_axis_tuser,   // operation
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // capdac_code[4:0], stats_valid[5], mean[31:6], min[57:32], max[83:58],
    // deviation[109:84], sample_total[120:110], window_overflow[121], zero fill
    output logic [127:0] m_axis_tdata,
    output logic         m_axis_tuser,   // kind
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import cws_pkg::*;

    localparam int unsigned AW   = $clog2(WINDOW_DEPTH);
    localparam int unsigned CW   = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned SUMW = ValW + CW;
    localparam logic [CapW-1:0] CapMax = CapW'(CAPDAC_MAX);
    localparam logic [CW-1:0]   Depth  = CW'(WINDOW_DEPTH);

    logic [ValW-1:0] mem [WINDOW_DEPTH];

    t_state          r_state, n_state;
    logic [14:0]     r_thresh;
    logic [1:0]      r_sat_lim;
    logic [SUMW-1:0] r_sum;
    logic [CW-1:0]   r_count;
    logic [ValW-1:0] r_min, r_max;
    logic [CapW-1:0] r_capdac;
    logic [1:0]      r_sat;
    logic            r_ovf;
    logic [CW-1:0]   r_idx;
    logic [ValW-1:0] r_rdata;
    logic [ValW-1:0] r_mean;
    logic [51:0]     r_prod;
    logic [VarW-1:0] r_vsum;
    logic [VarW-1:0] r_var;
    logic            r_oval;
    logic            r_okind;
    logic [121:0]    r_odata;

    t_unit_req       unit_req;
    logic [VarW-1:0] unit_a;
    logic            unit_done;
    logic [VarW-1:0] unit_res;

    logic            in_acc, cfg_wr;
    logic [15:0]     raw_hi, raw_lo;
    logic [26:0]     samp_sum;
    logic [ValW-1:0] samp_v;
    logic [16:0]     s_hi, th_pos;
    logic [CapW-1:0] cap_step;
    logic [ValW-1:0] diff;
    logic [1:0]      sat_inc;
    logic            sat_clr;
    logic [121:0]    samp_odata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == RegSatLimit) ? {30'b0, r_sat_lim} : {17'b0, r_thresh};

    assign s_axis_tready = (r_state == ST_IDLE) && !r_oval;
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign raw_hi = s_axis_tdata[15:0];
    assign raw_lo = s_axis_tdata[31:16];

    always_comb begin
        samp_sum = {3'b0, raw_hi, raw_lo[15:8]} + {1'b0, 10'(r_capdac * 5'd25), 16'b0};
        samp_v   = samp_sum[26] ? ValMax : samp_sum[ValW-1:0];
        s_hi     = {raw_hi[15], raw_hi};
        th_pos   = {2'b0, r_thresh};
        cap_step = r_capdac;
        if ($signed(s_hi) > $signed(th_pos)) begin
            if (r_capdac < CapMax) cap_step = r_capdac + 1'b1;
        end else if ($signed(s_hi) < -$signed(th_pos)) begin
            if (r_capdac != '0) cap_step = r_capdac - 1'b1;
        end
        diff    = (r_rdata >= r_mean) ? r_rdata - r_mean : r_mean - r_rdata;
        sat_inc = (r_capdac == CapMax && r_sat != 2'd3) ? r_sat + 2'd1 : r_sat;
        sat_clr = sat_inc > r_sat_lim;
        // sample acknowledgement beat
        samp_odata      = '0;
        samp_odata[4:0] = cap_step;
        if (r_count < Depth) begin
            samp_odata[120:110] = TotalW'(r_count + 1'b1);
            samp_odata[121]     = r_ovf;
        end else begin
            samp_odata[120:110] = TotalW'(r_count);
            samp_odata[121]     = 1'b1;
        end
    end

    always_comb begin
        n_state  = r_state;
        unit_req = '0;
        unit_a   = '0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && s_axis_tuser == OpWindowEnd)
                    n_state = (r_sum != '0) ? ST_MEAN_GO : ST_FINISH;
            end
            ST_MEAN_GO: begin
                unit_req = '{start: 1'b1, sqrt_mode: 1'b0};
                unit_a   = VarW'(r_sum);
                n_state  = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT: if (unit_done) n_state = ST_RD;
            ST_RD:        n_state = ST_SQ;
            ST_SQ:        n_state = ST_ACC;
            ST_ACC:       n_state = (r_idx + 1'b1 == r_count) ? ST_VAR_GO : ST_RD;
            ST_VAR_GO: begin
                unit_req = '{start: 1'b1, sqrt_mode: 1'b0};
                unit_a   = r_vsum;
                n_state  = ST_VAR_WAIT;
            end
            ST_VAR_WAIT:  if (unit_done) n_state = ST_SQRT_GO;
            ST_SQRT_GO: begin
                unit_req = '{start: 1'b1, sqrt_mode: 1'b1};
                unit_a   = r_var;
                n_state  = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT: if (unit_done) n_state = ST_FINISH;
            ST_FINISH:    n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    cws_divsqrt #(.CW(CW)) u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (unit_req),
        .i_a     (unit_a),
        .i_b     (r_count),
        .o_done  (unit_done),
        .o_res   (unit_res)
    );

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[r_idx[AW-1:0]];
        if (in_acc && s_axis_tuser == OpSample && r_count < Depth)
            mem[r_count[AW-1:0]] <= samp_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_thresh  <= 15'd16384;
            r_sat_lim <= 2'd2;
            r_sum     <= '0;
            r_count   <= '0;
            r_min     <= '0;
            r_max     <= '0;
            r_capdac  <= '0;
            r_sat     <= '0;
            r_ovf     <= 1'b0;
            r_oval    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                if (paddr[2] == RegThreshold) r_thresh <= pwdata[14:0];
                else r_sat_lim <= pwdata[1:0];
            end
            if (m_axis_tvalid && m_axis_tready) r_oval <= 1'b0;
            if (in_acc && s_axis_tuser == OpSample) begin
                r_capdac <= cap_step;
                r_oval   <= 1'b1;
                r_okind  <= OpSample;
                r_odata  <= samp_odata;
                if (r_count < Depth) begin
                    r_count <= r_count + 1'b1;
                    r_sum   <= r_sum + SUMW'(samp_v);
                    if (samp_v > r_max) r_max <= samp_v;
                    if (samp_v < r_min || r_min == '0) r_min <= samp_v;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (r_state == ST_FINISH) begin
                r_oval  <= 1'b1;
                r_okind <= OpWindowEnd;
                r_odata <= {r_ovf, TotalW'(r_count), unit_res[ValW-1:0] & {ValW{r_sum != '0}},
                            r_max, r_min, r_mean & {ValW{r_sum != '0}}, r_sum != '0,
                            sat_clr ? CapW'(0) : r_capdac};
                r_sum   <= '0;
                r_count <= '0;
                r_min   <= '0;
                r_max   <= '0;
                r_ovf   <= 1'b0;
                r_sat   <= sat_clr ? 2'd0 : sat_inc;
                if (sat_clr) r_capdac <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MEAN_WAIT && unit_done) begin
            r_mean <= unit_res[ValW-1:0];
            r_idx  <= '0;
            r_vsum <= '0;
        end
        if (r_state == ST_SQ) r_prod <= diff * diff;
        if (r_state == ST_ACC) begin
            r_vsum <= r_vsum + VarW'(r_prod);
            r_idx  <= r_idx + 1'b1;
        end
        if (r_state == ST_VAR_WAIT && unit_done) r_var <= unit_res;
    end

    assign m_axis_tvalid = r_oval;
    assign m_axis_tuser  = r_okind;
    assign m_axis_tdata  = {6'b0, r_odata};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Depth) else $error("sample count beyond store depth");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready) else $error("ready while sequencing");
    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH) |=> (r_oval && r_count == '0)) else $error("window not closed");
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQ) |-> (r_idx < r_count)) else $error("store walk past count");
`endif
endmodule

// ===== verif/tb.sv =====
// Testbench for capacitance_window_statistics_top: predicted window statistics vs. the stream output.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cws_pkg::*;

    typedef struct packed {
        logic              kind;
        logic [4:0]        capdac;
        logic              valid;
        logic [ValW-1:0]   mean;
        logic [ValW-1:0]   vmin;
        logic [ValW-1:0]   vmax;
        logic [ValW-1:0]   dev;
        logic [TotalW-1:0] total;
        logic              ovf;
    } t_stats;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic s_axis_tvalid = 0, s_axis_tuser = 0;
    logic [31:0] s_axis_tdata = '0;
    logic s_axis_tready;
    logic m_axis_tvalid, m_axis_tuser;
    logic m_axis_tready = 0;
    logic [127:0] m_axis_tdata;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0, prdata;
    logic pready;

    always #5 i_clk = ~i_clk;

    capacitance_window_statistics_top u_top (.*);

    // predictor state
    logic [14:0] thresh_q;
    logic [1:0] satlim_q;
    logic [ValW-1:0] win_store [DefWindowDepth];
    logic [35:0] win_sum;
    int unsigned win_cnt;
    logic [ValW-1:0] win_min, win_max;
    int unsigned capdac_q, sat_cnt;
    bit ovf_q;

    t_stats expected_q[$];
    int mismatches = 0;
    bit rx_idle = 0;
    bit hold_off = 0;

    function automatic logic [63:0] floor_sqrt(logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_stats predict_stats(logic op, logic [15:0] hi, logic [15:0] lo);
        t_stats r;
        logic [63:0] v, mean, vsum, d, dv;
        int signed s, th;
        r = '0;
        if (op == OpSample) begin
            v = {hi, lo} >> 8;
            v += 64'(capdac_q) * 64'd1638400;
            if (v > 64'(ValMax)) v = 64'(ValMax);
            s = $signed(hi);
            th = int'(thresh_q);
            if (win_cnt < DefWindowDepth) begin
                win_store[win_cnt] = v[ValW-1:0];
                win_cnt++;
                win_sum += v[35:0];
                if (v[ValW-1:0] > win_max) win_max = v[ValW-1:0];
                if (v[ValW-1:0] < win_min || win_min == 0) win_min = v[ValW-1:0];
            end else begin
                ovf_q = 1;
            end
            if (s > th) begin
                if (capdac_q < DefCapdacMax) capdac_q++;
            end else if (s < -th) begin
                if (capdac_q > 0) capdac_q--;
            end
            r.capdac = capdac_q[4:0];
        end else begin
            r.kind = 1'b1;
            if (win_sum != 0 && win_cnt != 0) begin
                r.valid = 1'b1;
                mean = 64'(win_sum) / win_cnt;
                vsum = 0;
                for (int i = 0; i < win_cnt; i++) begin
                    d = (64'(win_store[i]) >= mean) ? 64'(win_store[i]) - mean
                                                    : mean - 64'(win_store[i]);
                    vsum += d * d;
                end
                r.mean = mean[ValW-1:0];
                dv = floor_sqrt(vsum / win_cnt);
                r.dev = dv[ValW-1:0];
            end
            r.vmin = win_min;
            r.vmax = win_max;
            win_sum = '0; win_min = '0; win_max = '0;
            if (capdac_q == DefCapdacMax && sat_cnt < 3) sat_cnt++;
            if (sat_cnt > satlim_q) begin
                capdac_q = 0;
                sat_cnt = 0;
            end
            r.capdac = capdac_q[4:0];
        end
        r.total = win_cnt[TotalW-1:0];
        r.ovf = ovf_q;
        if (op == OpWindowEnd) begin
            win_cnt = 0;
            ovf_q = 0;
        end
        return r;
    endfunction

    // tvalid stays high after a beat so the next beat can follow at once;
    // wait_drain drops it when the sender goes quiet
    task automatic send_item(logic op, logic [15:0] hi, logic [15:0] lo, bit gaps = 1'b1);
        while (gaps && rx_idle == 0 && $urandom_range(99) < 15) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= op;
        s_axis_tdata <= {lo, hi};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_q.push_back(predict_stats(op, hi, lo));
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (idx == RegThreshold) thresh_q = val[14:0];
        else satlim_q = val[1:0];
        @(posedge i_clk);
    endtask

    // sampled at the clock edge where the beat is taken
    always @(posedge i_clk) begin
        t_stats got, exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind = m_axis_tuser;
            got.capdac = m_axis_tdata[4:0];
            got.valid = m_axis_tdata[5];
            got.mean = m_axis_tdata[31:6];
            got.vmin = m_axis_tdata[57:32];
            got.vmax = m_axis_tdata[83:58];
            got.dev = m_axis_tdata[109:84];
            got.total = m_axis_tdata[120:110];
            got.ovf = m_axis_tdata[121];
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", got);
            end else begin
                exp_r = expected_q.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", exp_r, got);
                end
            end
        end
    end

    // receiver: random stalls, idle-free stretch, and one long hold-off
    always @(posedge i_clk) begin
        if (hold_off) m_axis_tready <= 0;
        else m_axis_tready <= rx_idle ? 1'b1 : ($urandom_range(99) >= 15);
    end

    task automatic test_directed();
        send_item(OpWindowEnd, 16'h0000, 16'h0000);   // empty window
        send_item(OpSample, 16'h0000, 16'h0000);      // zero value, zero sum
        send_item(OpWindowEnd, 16'h0000, 16'h0000);
        send_item(OpSample, 16'h0000, 16'h0100);      // min-unset rule
        send_item(OpSample, 16'hFFFF, 16'hFFFF);
        send_item(OpSample, 16'h8000, 16'h00FF);
        send_item(OpSample, 16'h7FFF, 16'hFF00);
        send_item(OpWindowEnd, 16'h0000, 16'h0000);
        for (int i = 0; i < 35; i++) send_item(OpSample, 16'h7FFF, 16'h1234); // capdac to max
        send_item(OpSample, 16'h7FFF, 16'hFFFF);      // large value with capdac at max
        for (int i = 0; i < 4; i++) send_item(OpWindowEnd, 16'h0000, 16'h0000);
        send_item(OpSample, 16'h8000, 16'h0000);      // step down at zero
        send_item(OpWindowEnd, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_config();
        wait_drain();
        write_reg(RegThreshold, 32'h0000_7FFF);
        write_reg(RegSatLimit, 32'h0000_0003);
        for (int i = 0; i < 40; i++) send_item(OpSample, 16'h7FFF, 16'($urandom));
        for (int i = 0; i < 5; i++) send_item(OpWindowEnd, 16'h0000, 16'h0000);
        wait_drain();
        write_reg(RegThreshold, 32'h0000_0000);
        write_reg(RegSatLimit, 32'h0000_0000);
        for (int i = 0; i < 40; i++) send_item(OpSample, 16'h0001, 16'($urandom));
        send_item(OpWindowEnd, 16'h0000, 16'h0000);
        send_item(OpSample, 16'hFFFF, 16'h0000);
        send_item(OpSample, 16'h0000, 16'h0000);
        send_item(OpWindowEnd, 16'h0000, 16'h0000);
        wait_drain();
        write_reg(RegThreshold, 32'h0000_4000);
        write_reg(RegSatLimit, 32'h0000_0001);
    endtask

    // long stretch with no idling on either side
    task automatic test_store_full();
        wait_drain();
        rx_idle = 1;
        for (int i = 0; i < DefWindowDepth + 3; i++)
            send_item(OpSample, 16'($urandom_range(0, 16'h3FFF)), 16'($urandom), 1'b0);
        send_item(OpWindowEnd, 16'h0000, 16'h0000, 1'b0);
        rx_idle = 0;
    endtask

    task automatic test_backpressure();
        wait_drain();
        hold_off = 1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end
            for (int i = 0; i < 10; i++) send_item(OpSample, 16'($urandom), 16'($urandom));
        join
        send_item(OpWindowEnd, 16'h0000, 16'h0000);
        wait_drain();                                 // sender pauses until drained
    endtask

    task automatic test_random();
        int n, len;
        logic [15:0] hi;
        n = 0;
        rx_idle = 0;
        while (n < 75) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 24);
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(3))
                    0: hi = 16'($urandom);
                    1: hi = 16'($urandom_range(16'h3800, 16'h7FFF));
                    2: hi = 16'($urandom_range(16'h8000, 16'hC800));
                    default: hi = 16'($urandom_range(0, 16'h3FFF));
                endcase
                send_item(OpSample, hi, 16'($urandom));
            end
            send_item(OpWindowEnd, 16'($urandom), 16'($urandom));
            n += len + 1;
        end
    endtask

    initial begin
        thresh_q = 15'd16384; satlim_q = 2'd2;
        win_sum = '0; win_cnt = 0; win_min = '0; win_max = '0;
        capdac_q = 0; sat_cnt = 0; ovf_q = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_directed();
        test_config();
        test_store_full();
        test_backpressure();
        test_random();
        wait_drain();
        if (mismatches == 0 && expected_q.size() == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
